### rtl/core/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, field layouts, constants and the control store of the
// calendar date arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 23;
  localparam int DIFF_W  = 23;

  // day serial width: covers the last day of year 65535 and any sum with an offset
  localparam int SER_W   = 25;

  // sequencer program counter width
  localparam int PC_W    = 5;

  // stream data widths, whole bytes
  localparam int IN_W    = 72;
  localparam int OUT_W   = 56;

  localparam logic [MON_W-1:0] MONTHS = MON_W'(12);

  localparam logic signed [SER_W:0] DIFF_MAX = (SER_W+1)'(4194303);
  localparam logic signed [SER_W:0] DIFF_MIN = (SER_W+1)'(-4194304);

  // request payload, last field in the lowest bits
  typedef struct packed {
    logic signed [OFF_W-1:0] offset;
    logic [DAY_W-1:0]        day_b;
    logic [MON_W-1:0]        month_b;
    logic [YEAR_W-1:0]       year_b;
    logic [DAY_W-1:0]        day_a;
    logic [MON_W-1:0]        month_a;
    logic [YEAR_W-1:0]       year_a;
  } req_t;

  // result payload, last field in the lowest bits
  typedef struct packed {
    logic                    out_of_range;
    logic                    is_greater;
    logic                    is_equal;
    logic [DIFF_W-1:0]       difference;
    logic [DAY_W-1:0]        day_out;
    logic [MON_W-1:0]        month_out;
    logic [YEAR_W-1:0]       year_out;
  } res_t;

  // micro-operations
  typedef logic [3:0] op_t;
  localparam op_t OP_LOAD_A    = 4'd0;
  localparam op_t OP_LOAD_B    = 4'd1;
  localparam op_t OP_RED       = 4'd2;
  localparam op_t OP_MON       = 4'd3;
  localparam op_t OP_SAVE_A    = 4'd4;
  localparam op_t OP_SETUP_REV = 4'd5;
  localparam op_t OP_FIN_DATE  = 4'd6;
  localparam op_t OP_DIFF      = 4'd7;
  localparam op_t OP_EMIT      = 4'd8;

  // reduction stage: 400-year, 100-year, 4-year and 1-year blocks
  typedef logic [1:0] stage_t;
  localparam stage_t ST_400 = 2'd0;
  localparam stage_t ST_100 = 2'd1;
  localparam stage_t ST_4   = 2'd2;
  localparam stage_t ST_1   = 2'd3;

  // next-address control
  typedef logic [2:0] cond_t;
  localparam cond_t C_NEXT = 3'd0;  // fall through
  localparam cond_t C_LOOP = 3'd1;  // repeat while the step still applies
  localparam cond_t C_KIND = 3'd2;  // jump on difference request
  localparam cond_t C_JUMP = 3'd3;  // always jump
  localparam cond_t C_OOR  = 3'd4;  // jump when the sum left the calendar

  typedef struct packed {
    op_t             op;
    stage_t          stage;
    logic            rev;    // serial to date direction
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } cw_t;

  // jump targets
  localparam logic [PC_W-1:0] PC_DATE_B = PC_W'(14);
  localparam logic [PC_W-1:0] PC_EMIT   = PC_W'(21);

  function automatic cw_t mk_cw(op_t op, stage_t stage, logic rev, cond_t cond,
                                logic [PC_W-1:0] tgt);
    cw_t w;
    w.op    = op;
    w.stage = stage;
    w.rev   = rev;
    w.cond  = cond;
    w.tgt   = tgt;
    return w;
  endfunction

  // control store
  function automatic cw_t ucode_rom(logic [PC_W-1:0] pc);
    cw_t w;
    unique case (pc)
      // serial of date A
      5'd0:    w = mk_cw(OP_LOAD_A,    ST_400, 1'b0, C_NEXT, PC_EMIT);
      5'd1:    w = mk_cw(OP_RED,       ST_400, 1'b0, C_LOOP, PC_EMIT);
      5'd2:    w = mk_cw(OP_RED,       ST_100, 1'b0, C_LOOP, PC_EMIT);
      5'd3:    w = mk_cw(OP_RED,       ST_4,   1'b0, C_LOOP, PC_EMIT);
      5'd4:    w = mk_cw(OP_RED,       ST_1,   1'b0, C_LOOP, PC_EMIT);
      5'd5:    w = mk_cw(OP_MON,       ST_400, 1'b0, C_LOOP, PC_EMIT);
      5'd6:    w = mk_cw(OP_SAVE_A,    ST_400, 1'b0, C_KIND, PC_DATE_B);
      // add offset, serial back to a date
      5'd7:    w = mk_cw(OP_SETUP_REV, ST_400, 1'b1, C_OOR,  PC_EMIT);
      5'd8:    w = mk_cw(OP_RED,       ST_400, 1'b1, C_LOOP, PC_EMIT);
      5'd9:    w = mk_cw(OP_RED,       ST_100, 1'b1, C_LOOP, PC_EMIT);
      5'd10:   w = mk_cw(OP_RED,       ST_4,   1'b1, C_LOOP, PC_EMIT);
      5'd11:   w = mk_cw(OP_RED,       ST_1,   1'b1, C_LOOP, PC_EMIT);
      5'd12:   w = mk_cw(OP_MON,       ST_400, 1'b1, C_LOOP, PC_EMIT);
      5'd13:   w = mk_cw(OP_FIN_DATE,  ST_400, 1'b1, C_JUMP, PC_EMIT);
      // serial of date B and difference
      5'd14:   w = mk_cw(OP_LOAD_B,    ST_400, 1'b0, C_NEXT, PC_EMIT);
      5'd15:   w = mk_cw(OP_RED,       ST_400, 1'b0, C_LOOP, PC_EMIT);
      5'd16:   w = mk_cw(OP_RED,       ST_100, 1'b0, C_LOOP, PC_EMIT);
      5'd17:   w = mk_cw(OP_RED,       ST_4,   1'b0, C_LOOP, PC_EMIT);
      5'd18:   w = mk_cw(OP_RED,       ST_1,   1'b0, C_LOOP, PC_EMIT);
      5'd19:   w = mk_cw(OP_MON,       ST_400, 1'b0, C_LOOP, PC_EMIT);
      5'd20:   w = mk_cw(OP_DIFF,      ST_400, 1'b0, C_NEXT, PC_EMIT);
      5'd21:   w = mk_cw(OP_EMIT,      ST_400, 1'b0, C_NEXT, PC_EMIT);
      default: w = mk_cw(OP_EMIT,      ST_400, 1'b0, C_NEXT, PC_EMIT);
    endcase
    return w;
  endfunction

  // years in one block of a stage
  function automatic logic [8:0] blk_years(stage_t st);
    logic [8:0] v;
    unique case (st)
      ST_400:  v = 9'd400;
      ST_100:  v = 9'd100;
      ST_4:    v = 9'd4;
      default: v = 9'd1;
    endcase
    return v;
  endfunction

  // days in one block of a stage
  function automatic logic [17:0] blk_days(stage_t st);
    logic [17:0] v;
    unique case (st)
      ST_400:  v = 18'd146097;
      ST_100:  v = 18'd36524;
      ST_4:    v = 18'd1461;
      default: v = 18'd365;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [MON_W-1:0] mo, logic leap);
    logic [DAY_W-1:0] v;
    unique case (mo)
      4'd2:                     v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  v = 5'd30;
      default:                  v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/calendar_date_arithmetic.sv
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// Gregorian date arithmetic: with tuser 0 a signed day offset is added to
// date A and the sum is normalized back to year, month and day; with tuser 1
// the unit returns the days from B to A with equal and greater flags. Dates
// map to a day serial counted from 0001-01-01 (day 1). A year of 0 reads as
// 1, months are clamped to 1..12, and day 0 or days past the month's end roll
// into neighboring months. Sums outside 0001-01-01..MAX_YEAR-12-31 saturate
// and differences beyond 23 bits saturate, both raising out_of_range. One
// request is processed at a time by a small microcoded sequencer that walks
// 400/100/4/1-year blocks and then months with one shared subtract and
// accumulate step per cycle. The time from acceptance to out_tvalid is set
// by the number of block and month iterations (an add needs two walks, one
// per direction, unless the sum leaves the calendar, and a difference two
// forward walks), plus any wait of the finished result for the output
// register to drain.
// The result sits in an output register, so the next request is accepted as
// soon as the previous result has been placed there.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_arithmetic
  import cda_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_tvalid,
  output logic             in_tready,
  // year_a[13:0], month_a[17:14], day_a[22:18], year_b[36:23], month_b[40:37],
  // day_b[45:41], offset[68:46], zero pad[71:69]
  input  logic [IN_W-1:0]  in_tdata,
  // kind[0]: 0 add offset, 1 difference
  input  logic [0:0]       in_tuser,

  output logic             out_tvalid,
  input  logic             out_tready,
  // year_out[13:0], month_out[17:14], day_out[22:18], difference[45:23],
  // is_equal[46], is_greater[47], out_of_range[48], zero pad[55:49]
  output logic [OUT_W-1:0] out_tdata
);

  // serial of MAX_YEAR-12-31
  localparam int TOP_SER = 365*MAX_YEAR + MAX_YEAR/4 - MAX_YEAR/100 + MAX_YEAR/400;
  localparam logic signed [SER_W:0]  TOP_S    = (SER_W+1)'(TOP_SER);
  localparam logic signed [SER_W:0]  ONE_S    = (SER_W+1)'(1);
  localparam logic signed [SER_W:0]  ZERO_S   = (SER_W+1)'(0);
  localparam logic [YEAR_W-1:0]      SAT_YEAR = YEAR_W'(MAX_YEAR);

  // sequencer control
  logic              busy_r, busy_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  cw_t               cw;

  // captured transaction
  req_t              req_r;
  logic              kind_r;

  // datapath
  logic [SER_W-1:0]  x_r, x_nxt;        // value being walked down
  logic [SER_W-1:0]  acc_r, acc_nxt;    // serial (forward) or year (reverse)
  logic [SER_W-1:0]  sa_r, sa_nxt;      // serial of date A
  logic [1:0]        q100_r, q100_nxt;  // century blocks in the current 400
  logic [4:0]        q4_r, q4_nxt;      // leap cycles in the current century
  logic [1:0]        q1_r, q1_nxt;      // years in the current leap cycle
  logic [MON_W-1:0]  mo_r, mo_nxt;
  logic [MON_W-1:0]  mlim_r, mlim_nxt;
  logic [DAY_W-1:0]  dd_r, dd_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r;

  logic [YEAR_W-1:0] ld_year, ld_p;
  logic [MON_W-1:0]  ld_month, ld_mon;
  logic [DAY_W-1:0]  ld_day;
  logic              leap;
  logic [DAY_W-1:0]  ml;
  logic [SER_W-1:0]  sub_amt, add_amt;
  logic              capped, red_go, mon_go, loop_go;
  logic [SER_W-1:0]  ser_fin;
  logic signed [SER_W:0] off_sum, diff_full, diff_sat;
  logic              add_lo, add_hi, add_oor;

  assign in_tready  = ~busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-$bits(res_t)){1'b0}}, out_r};

  assign cw = ucode_rom(pc_r);

  // operand select and clamping for the forward walk
  assign ld_year  = (cw.op == OP_LOAD_B) ? req_r.year_b  : req_r.year_a;
  assign ld_month = (cw.op == OP_LOAD_B) ? req_r.month_b : req_r.month_a;
  assign ld_day   = (cw.op == OP_LOAD_B) ? req_r.day_b   : req_r.day_a;
  assign ld_p     = (ld_year == '0) ? '0 : ld_year - YEAR_W'(1);
  assign ld_mon   = (ld_month == '0)    ? MON_W'(1) :
                    (ld_month > MONTHS) ? MONTHS    : ld_month;

  // leap year from the block counts: year is 3 mod 4 in its cycle, and not
  // the last year of a century unless it also closes the 400-year block
  assign leap = (q1_r == 2'd3) && ((q4_r != 5'd24) || (q100_r == 2'd3));
  assign ml   = month_len(mo_r, leap);

  // one block step: forward subtracts years and adds days, reverse the opposite
  assign sub_amt = cw.rev ? SER_W'(blk_days(cw.stage))  : SER_W'(blk_years(cw.stage));
  assign add_amt = cw.rev ? SER_W'(blk_years(cw.stage)) : SER_W'(blk_days(cw.stage));
  assign capped  = ((cw.stage == ST_100) && (q100_r == 2'd3)) ||
                   ((cw.stage == ST_1)   && (q1_r   == 2'd3));
  assign red_go  = (x_r >= sub_amt) && !capped;
  assign mon_go  = cw.rev ? ((mo_r < MONTHS) && (x_r >= SER_W'(ml))) : (mo_r < mlim_r);
  assign loop_go = (cw.op == OP_MON) ? mon_go : red_go;

  // finished serial of the date just walked
  assign ser_fin = acc_r + SER_W'(dd_r);

  // offset add and range check
  assign off_sum = $signed({1'b0, sa_r}) + (SER_W+1)'($signed(req_r.offset));
  assign add_lo  = off_sum < ONE_S;
  assign add_hi  = off_sum > TOP_S;
  assign add_oor = add_lo | add_hi;

  // difference with saturation to the 23-bit field
  assign diff_full = $signed({1'b0, sa_r}) - $signed({1'b0, ser_fin});
  assign diff_sat  = (diff_full > DIFF_MAX) ? DIFF_MAX :
                     (diff_full < DIFF_MIN) ? DIFF_MIN : diff_full;

  // datapath next state, driven by the current control word
  always_comb begin
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    sa_nxt   = sa_r;
    q100_nxt = q100_r;
    q4_nxt   = q4_r;
    q1_nxt   = q1_r;
    mo_nxt   = mo_r;
    mlim_nxt = mlim_r;
    dd_nxt   = dd_r;
    res_nxt  = res_r;
    if (busy_r) begin
      unique case (cw.op)
        OP_LOAD_A, OP_LOAD_B: begin
          x_nxt    = SER_W'(ld_p);
          acc_nxt  = '0;
          q100_nxt = '0;
          q4_nxt   = '0;
          q1_nxt   = '0;
          mo_nxt   = MON_W'(1);
          mlim_nxt = ld_mon;
          dd_nxt   = ld_day;
        end
        OP_RED: begin
          if (red_go) begin
            x_nxt   = x_r - sub_amt;
            acc_nxt = acc_r + add_amt;
            unique case (cw.stage)
              ST_100:  q100_nxt = q100_r + 2'd1;
              ST_4:    q4_nxt   = q4_r + 5'd1;
              ST_1:    q1_nxt   = q1_r + 2'd1;
              default: ;
            endcase
          end
        end
        OP_MON: begin
          if (mon_go) begin
            if (cw.rev) begin
              x_nxt = x_r - SER_W'(ml);
            end else begin
              acc_nxt = acc_r + SER_W'(ml);
            end
            mo_nxt = mo_r + MON_W'(1);
          end
        end
        OP_SAVE_A: begin
          sa_nxt = ser_fin;
        end
        OP_SETUP_REV: begin
          res_nxt = '0;
          priority if (add_lo) begin
            res_nxt.out_of_range = 1'b1;
            res_nxt.year_out     = YEAR_W'(1);
            res_nxt.month_out    = MON_W'(1);
            res_nxt.day_out      = DAY_W'(1);
          end else if (add_hi) begin
            res_nxt.out_of_range = 1'b1;
            res_nxt.year_out     = SAT_YEAR;
            res_nxt.month_out    = MONTHS;
            res_nxt.day_out      = DAY_W'(31);
          end else begin
            // day index from 0001-01-01, year counted from 1
            x_nxt    = off_sum[SER_W-1:0] - SER_W'(1);
            acc_nxt  = SER_W'(1);
            q100_nxt = '0;
            q4_nxt   = '0;
            q1_nxt   = '0;
            mo_nxt   = MON_W'(1);
          end
        end
        OP_FIN_DATE: begin
          res_nxt           = '0;
          res_nxt.year_out  = acc_r[YEAR_W-1:0];
          res_nxt.month_out = mo_r;
          res_nxt.day_out   = x_r[DAY_W-1:0] + DAY_W'(1);
        end
        OP_DIFF: begin
          res_nxt              = '0;
          res_nxt.difference   = diff_sat[DIFF_W-1:0];
          res_nxt.out_of_range = (diff_full > DIFF_MAX) || (diff_full < DIFF_MIN);
          res_nxt.is_equal     = (diff_full == ZERO_S);
          res_nxt.is_greater   = (diff_full > ZERO_S);
        end
        default: ;
      endcase
    end
  end

  // sequencer: next address and output handoff
  always_comb begin
    pc_nxt        = pc_r;
    busy_nxt      = busy_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    if (!busy_r) begin
      if (in_tvalid) begin
        pc_nxt   = '0;
        busy_nxt = 1'b1;
      end
    end else begin
      priority if (cw.op == OP_EMIT) begin
        // hold here until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          busy_nxt      = 1'b0;
          pc_nxt        = '0;
        end
      end else begin
        unique case (cw.cond)
          C_LOOP:  pc_nxt = loop_go ? pc_r : pc_r + PC_W'(1);
          C_KIND:  pc_nxt = kind_r  ? cw.tgt : pc_r + PC_W'(1);
          C_JUMP:  pc_nxt = cw.tgt;
          C_OOR:   pc_nxt = add_oor ? cw.tgt : pc_r + PC_W'(1);
          default: pc_nxt = pc_r + PC_W'(1);
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r  <= req_t'(in_tdata[$bits(req_t)-1:0]);
      kind_r <= in_tuser[0];
    end
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    sa_r   <= sa_nxt;
    q100_r <= q100_nxt;
    q4_r   <= q4_nxt;
    q1_r   <= q1_nxt;
    mo_r   <= mo_nxt;
    mlim_r <= mlim_nxt;
    dd_r   <= dd_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar date arithmetic unit. Requests (add
// an offset to a date, or difference and compare two dates) are fed through
// the input stream with random gaps. Each accepted transaction is run through
// a day-serial model of the Gregorian calendar, and every returned result is
// compared field by field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------

module tb_top;
  import cda_pkg::*;

  localparam int LAST_YEAR = 9999;
  localparam int NUM_RANDOM = 500;

  typedef enum bit {
    KIND_ADD  = 1'b0,
    KIND_DIFF = 1'b1
  } kind_e;

  // one queued request; hold_for_drain makes the driver wait until every
  // outstanding result has come back before presenting it
  typedef struct {
    kind_e kind;
    req_t  req;
    bit    hold_for_drain;
  } date_request_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // year_a, month_a, day_a, year_b, month_b, day_b, offset, zero pad
  logic [IN_W-1:0]  in_tdata = '0;
  // kind
  logic [0:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // year_out, month_out, day_out, difference, is_equal, is_greater,
  // out_of_range, zero pad
  logic [OUT_W-1:0] out_tdata;

  date_request_t pending_requests[$];
  res_t          predicted_results[$];
  int            total_requests = 0;
  int            accepted_count = 0;
  int            error_count = 0;
  int unsigned   send_idle_left = 0;
  int unsigned   recv_stall_left = 0;
  bit            send_quiet = 1'b0;
  bit            recv_quiet = 1'b0;

  calendar_date_arithmetic #(
    .MAX_YEAR(LAST_YEAR)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // calendar model
  // ---------------------------------------------------------------------------

  function automatic int days_in_month(longint yr, int mo);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mo)
      2:            return leap ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  // days since 0000-12-31; year 0 reads as 1, month clamped to 1..12,
  // the day is added as is so day 0 and day excess roll over naturally
  function automatic longint day_number(logic [YEAR_W-1:0] yr, logic [MON_W-1:0] mo,
                                        logic [DAY_W-1:0] dy);
    longint y;
    longint p;
    longint s;
    int     m;
    y = yr;
    if (y < 1) y = 1;
    m = mo;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    p = y - 1;
    s = 365 * p + p / 4 - p / 100 + p / 400;
    for (int i = 1; i < m; i++) s += days_in_month(y, i);
    return s + dy;
  endfunction

  function automatic res_t predict_result(kind_e kind, req_t r);
    res_t   res;
    longint a;
    longint b;
    longint s;
    longint diff;
    longint last_day;
    longint rem;
    longint q400;
    longint q100;
    longint q4;
    longint q1;
    longint y;
    int     m;
    res = '0;
    a = day_number(r.year_a, r.month_a, r.day_a);
    if (kind == KIND_ADD) begin
      s = a + longint'($signed(r.offset));
      last_day = 365 * longint'(LAST_YEAR) + LAST_YEAR / 4 - LAST_YEAR / 100
                 + LAST_YEAR / 400;
      if (s < 1) begin
        // before the first day of year 1
        y = 1;
        m = 1;
        rem = 0;
        res.out_of_range = 1'b1;
      end else if (s > last_day) begin
        // past the last day of the last supported year
        y = LAST_YEAR;
        m = 12;
        rem = 30;
        res.out_of_range = 1'b1;
      end else begin
        // peel off 400, 100, 4 and 1 year blocks, then months
        rem = s - 1;
        q400 = rem / 146097;
        rem = rem % 146097;
        q100 = rem / 36524;
        if (q100 > 3) q100 = 3;
        rem -= q100 * 36524;
        q4 = rem / 1461;
        rem = rem % 1461;
        q1 = rem / 365;
        if (q1 > 3) q1 = 3;
        rem -= q1 * 365;
        y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
        m = 1;
        while (m < 12 && rem >= days_in_month(y, m)) begin
          rem -= days_in_month(y, m);
          m++;
        end
      end
      res.year_out  = y[YEAR_W-1:0];
      res.month_out = m[MON_W-1:0];
      res.day_out   = DAY_W'(rem + 1);
    end else begin
      b = day_number(r.year_b, r.month_b, r.day_b);
      diff = a - b;
      if (diff > 4194303) begin
        diff = 4194303;
        res.out_of_range = 1'b1;
      end
      if (diff < -4194304) begin
        diff = -4194304;
        res.out_of_range = 1'b1;
      end
      res.difference = diff[DIFF_W-1:0];
      res.is_equal   = (a == b);
      res.is_greater = (a > b);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // years clustered around the range ends and century boundaries
  function automatic int pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 5);
      1:       return $urandom_range(LAST_YEAR - 9, LAST_YEAR);
      2:       return 100 * $urandom_range(1, 99) + $urandom_range(0, 2) - 1;
      default: return $urandom_range(1, LAST_YEAR);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 4))
      0:       return int'($urandom_range(0, 80)) - 40;
      1:       return int'($urandom_range(0, 2000)) - 1000;
      2:       return int'($urandom_range(0, 400000)) - 200000;
      default: return int'($urandom_range(0, 32'h7F_FFFF)) - 4194304;
    endcase
  endfunction

  task automatic queue_request(kind_e kind, int ya, int ma, int da, int yb, int mb,
                               int db, int offset);
    date_request_t t;
    t.kind = kind;
    t.req.year_a = YEAR_W'(ya);
    t.req.month_a = MON_W'(ma);
    t.req.day_a = DAY_W'(da);
    t.req.year_b = YEAR_W'(yb);
    t.req.month_b = MON_W'(mb);
    t.req.day_b = DAY_W'(db);
    t.req.offset = OFF_W'(offset);
    t.hold_for_drain = 1'b0;
    pending_requests.push_back(t);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued requests, idles between transactions
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_requests
    date_request_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_idle_left <= 0;
    end else begin
      // accepted transaction: predict from exactly what the block sampled
      if (in_tvalid && in_tready) begin
        predicted_results.push_back(predict_result(kind_e'(in_tuser),
                                                   req_t'(in_tdata[$bits(req_t)-1:0])));
        accepted_count++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the current transaction until it is taken
      end else if (send_idle_left != 0) begin
        send_idle_left <= send_idle_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].hold_for_drain && predicted_results.size() != 0)) begin
        nxt = pending_requests.pop_front();
        in_tdata <= IN_W'(nxt.req);
        in_tuser <= nxt.kind;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        send_idle_left <= draw_wait(send_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stalls the result stream at random and checks each transaction
  // ---------------------------------------------------------------------------

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t        got;
    res_t        want;
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall_left <= draw_wait(recv_quiet);
    end else if (out_tvalid && out_tready) begin
      got = res_t'(out_tdata[$bits(res_t)-1:0]);
      if (predicted_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("year_out", want.year_out, got.year_out);
        check_field("month_out", want.month_out, got.month_out);
        check_field("day_out", want.day_out, got.day_out);
        check_field("difference", $signed(want.difference), $signed(got.difference));
        check_field("is_equal", want.is_equal, got.is_equal);
        check_field("is_greater", want.is_greater, got.is_greater);
        check_field("out_of_range", want.out_of_range, got.out_of_range);
      end
      if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
      stall = draw_wait(recv_quiet);
      recv_stall_left <= stall;
      out_tready <= (stall == 0);
    end else if (out_tvalid && recv_stall_left != 0) begin
      // stall counts only while a result is waiting
      recv_stall_left <= recv_stall_left - 1;
      out_tready <= (recv_stall_left == 1);
    end else begin
      out_tready <= (recv_stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : run_sequence
    date_request_t t;
    logic [95:0]   noise;

    // adds: range ends, saturation both ways
    queue_request(KIND_ADD, 1, 1, 1, 0, 0, 0, 0);
    queue_request(KIND_ADD, 1, 1, 1, 0, 0, 0, -1);
    queue_request(KIND_ADD, 9999, 12, 31, 0, 0, 0, 0);
    queue_request(KIND_ADD, 9999, 12, 31, 16383, 15, 31, 1);
    queue_request(KIND_ADD, 1, 1, 1, 0, 0, 0, 4194303);
    queue_request(KIND_ADD, 9999, 12, 31, 0, 0, 0, -4194304);
    queue_request(KIND_ADD, 16383, 15, 31, 0, 0, 0, 0);
    queue_request(KIND_ADD, 16383, 1, 1, 0, 0, 0, -2400000);
    // year zero, month zero and month above 12
    queue_request(KIND_ADD, 0, 3, 1, 0, 0, 0, 0);
    queue_request(KIND_ADD, 2023, 0, 15, 0, 0, 0, 0);
    queue_request(KIND_ADD, 2023, 15, 10, 0, 0, 0, 0);
    // day zero, day past month end, leap rules
    queue_request(KIND_ADD, 2024, 3, 0, 0, 0, 0, 0);
    queue_request(KIND_ADD, 2023, 2, 31, 0, 0, 0, 0);
    queue_request(KIND_ADD, 1900, 2, 28, 0, 0, 0, 1);
    queue_request(KIND_ADD, 2000, 2, 28, 0, 0, 0, 1);
    queue_request(KIND_ADD, 2024, 12, 31, 0, 0, 0, 1);
    // differences: equal, both orders, saturation both ways
    queue_request(KIND_DIFF, 2024, 3, 0, 2024, 2, 29, 4194303);
    queue_request(KIND_DIFF, 0, 1, 1, 1, 0, 1, 0);
    queue_request(KIND_DIFF, 2000, 1, 1, 1999, 12, 31, -4194304);
    queue_request(KIND_DIFF, 1999, 12, 31, 2000, 1, 1, 0);
    queue_request(KIND_DIFF, 9999, 12, 31, 1, 1, 1, 0);
    queue_request(KIND_DIFF, 16383, 15, 31, 1, 1, 0, 0);
    queue_request(KIND_DIFF, 0, 0, 0, 16383, 15, 31, 0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 6) == 0) begin
        // raw bit patterns over every field
        noise = {$urandom, $urandom, $urandom};
        t.req = noise[$bits(req_t)-1:0];
        t.kind = kind_e'(noise[95]);
      end else begin
        t.kind = kind_e'($urandom_range(0, 1));
        t.req.year_a = YEAR_W'(pick_year());
        t.req.month_a = MON_W'($urandom_range(1, 12));
        t.req.day_a = DAY_W'($urandom_range(1, 31));
        if ($urandom_range(0, 9) == 0) begin
          t.req.year_b = t.req.year_a;
          t.req.month_b = t.req.month_a;
          t.req.day_b = t.req.day_a;
        end else begin
          t.req.year_b = YEAR_W'(pick_year());
          t.req.month_b = MON_W'($urandom_range(1, 12));
          t.req.day_b = DAY_W'($urandom_range(1, 31));
        end
        t.req.offset = OFF_W'(pick_offset());
      end
      // the first random transaction waits for the directed ones to drain
      t.hold_for_drain = (n == 0) || ($urandom_range(0, 99) == 0);
      pending_requests.push_back(t);
    end
    total_requests = pending_requests.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_requests || predicted_results.size() != 0)
      @(posedge clk);
    // allow for any stray result after the last expected one
    repeat (400) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
